// ===== src/ccfb_pkg.sv =====
package ccfb_pkg;

  localparam int unsigned WORD_W = 12;

  localparam logic [WORD_W-1:0] WORD_SPOOL_STOP  = 12'h902;
  localparam logic [WORD_W-1:0] WORD_SPOOL_START = 12'h900;
  localparam logic [7:0]        FLAG_START       = 8'h8E;
  localparam logic [7:0]        FLAG_ESC         = 8'h9E;
  localparam logic [7:0]        FLAG_END         = 8'hAE;
  localparam logic [7:0]        ESC_OFFSET       = 8'h0D;
  localparam logic [15:0]       CRC_INIT         = 16'h1D0F;
  localparam logic [15:0]       CRC_POLY         = 16'h1021;
  localparam logic [7:0]        STATUS_BYTE      = 8'hFF;

  localparam logic [3:0] HDR_LAST       = 4'd4;
  localparam logic [3:0] BODY_LAST_NOVAL = 4'd7;
  localparam logic [3:0] BODY_LAST_VAL  = 4'd11;
  localparam logic [3:0] CRC_LAST       = 4'd1;

  typedef enum logic [2:0] {
    SRC_STOP  = 3'd0,
    SRC_SOF   = 3'd1,
    SRC_HDR   = 3'd2,
    SRC_BODY  = 3'd3,
    SRC_CRC   = 3'd4,
    SRC_EOF   = 3'd5,
    SRC_SPOOL = 3'd6
  } src_e;

  typedef struct packed {
    logic       load;
    logic       emit;
    src_e       src;
    logic [2:0] hdr_idx;
    logic       esc_hi;
    logic       esc_lo;
    logic       shift;
    logic       crc_upd;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic body_flag;
    logic crc_flag;
  } sts_t;

  function automatic logic [7:0] hdr_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'h12;
      3'd2:    b = 8'hC0;
      3'd3:    b = 8'hFF;
      3'd4:    b = 8'hEE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_flag(logic [7:0] b);
    return (b == FLAG_START) || (b == FLAG_ESC) || (b == FLAG_END);
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/ccfb_if.sv =====
interface ccfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [31:0] func;
  logic [31:0] value;
  logic        has_value;

  modport source (output valid, output func, output value, output has_value, input ready);
  modport sink   (input valid, input func, input value, input has_value, output ready);
endinterface

interface ccfb_frame_if;
  logic                           valid;
  logic                           ready;
  logic [ccfb_pkg::WORD_W-1:0]    out_word;
  logic                           last;

  modport source (output valid, output out_word, output last, input ready);
  modport sink   (input valid, input out_word, input last, output ready);
endinterface

// ===== src/camera_command_frame_builder.sv =====
// Camera command frame builder.
// cmd_i (sink) carries one command: func, value and has_value. frame_o
// (source) carries the frame as 12-bit I2C write words, one word per
// transaction, with last set on the closing spool-start word 0x900.
// A frame is 19 to 25 words without a value and 23 to 33 words with one,
// the spread set by how many bytes need an escape pair.
// A controller walks the frame one word per cycle while frame_o does not
// stall; a datapath holds the command bytes, the running CRC and the
// output register. After a command is taken the controller moves to its
// STOP state and the first word is then loaded into the output register.
// cmd_i.ready is high only while the controller is idle, so a new command
// is taken only once the last word of the previous frame has been loaded.
// When frame_o stalls, the output register holds its word and the
// controller halts; nothing is dropped.
// Reset returns the controller to idle and empties the output register.
module camera_command_frame_builder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ccfb_cmd_if.sink             cmd_i,
  ccfb_frame_if.source         frame_o
);

  ccfb_pkg::cmd_t cmd;
  ccfb_pkg::sts_t sts;

  ccfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .has_value_i (cmd_i.has_value),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ccfb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (cmd_i.func),
    .value_i     (cmd_i.value),
    .out_ready_i (frame_o.ready),
    .sts_o       (sts),
    .out_valid_o (frame_o.valid),
    .out_word_o  (frame_o.out_word),
    .out_last_o  (frame_o.last)
  );

endmodule

// ===== src/ccfb_ctrl.sv =====
module ccfb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            has_value_i,
  input  ccfb_pkg::sts_t  sts_i,
  output ccfb_pkg::cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_STOP  = 8'b0000_0010,
    S_SOF   = 8'b0000_0100,
    S_HDR   = 8'b0000_1000,
    S_BODY  = 8'b0001_0000,
    S_CRC   = 8'b0010_0000,
    S_EOF   = 8'b0100_0000,
    S_SPOOL = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       esc_q, esc_d;
  logic       has_val_q, has_val_d;
  logic [3:0] body_last;

  assign body_last  = has_val_q ? ccfb_pkg::BODY_LAST_VAL : ccfb_pkg::BODY_LAST_NOVAL;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    esc_d     = esc_q;
    has_val_d = has_val_q;
    cmd_o     = '0;
    cmd_o.src = ccfb_pkg::SRC_STOP;
    cmd_o.hdr_idx = cnt_q[2:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          has_val_d  = has_value_i;
          cnt_d      = '0;
          esc_d      = 1'b0;
          state_d    = S_STOP;
        end
      end
      S_STOP: begin
        cmd_o.src = ccfb_pkg::SRC_STOP;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_SOF;
        end
      end
      S_SOF: begin
        cmd_o.src = ccfb_pkg::SRC_SOF;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cnt_d      = '0;
          state_d    = S_HDR;
        end
      end
      S_HDR: begin
        cmd_o.src = ccfb_pkg::SRC_HDR;
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.crc_upd = 1'b1;
          if (cnt_q == ccfb_pkg::HDR_LAST) begin
            cnt_d   = '0;
            state_d = S_BODY;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      S_BODY: begin
        cmd_o.src = ccfb_pkg::SRC_BODY;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.body_flag && !esc_q) begin
            cmd_o.esc_hi = 1'b1;
            esc_d        = 1'b1;
          end else begin
            cmd_o.esc_lo  = esc_q;
            cmd_o.shift   = 1'b1;
            cmd_o.crc_upd = 1'b1;
            esc_d         = 1'b0;
            if (cnt_q == body_last) begin
              cnt_d   = '0;
              state_d = S_CRC;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
        end
      end
      S_CRC: begin
        cmd_o.src = ccfb_pkg::SRC_CRC;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.crc_flag && !esc_q) begin
            cmd_o.esc_hi = 1'b1;
            esc_d        = 1'b1;
          end else begin
            cmd_o.esc_lo = esc_q;
            cmd_o.shift  = 1'b1;
            esc_d        = 1'b0;
            if (cnt_q == ccfb_pkg::CRC_LAST) begin
              cnt_d   = '0;
              state_d = S_EOF;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
        end
      end
      S_EOF: begin
        cmd_o.src = ccfb_pkg::SRC_EOF;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_SPOOL;
        end
      end
      S_SPOOL: begin
        cmd_o.src  = ccfb_pkg::SRC_SPOOL;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      esc_q     <= 1'b0;
      has_val_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      esc_q     <= esc_d;
      has_val_q <= has_val_d;
    end
  end

  a_idle_no_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !esc_q)
    else $error("escape pending while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_STOP))
    else $error("accepted command did not start a frame");

  a_body_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BODY) |-> (cnt_q <= body_last))
    else $error("body index out of range");

endmodule

// ===== src/ccfb_dp.sv =====
module ccfb_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccfb_pkg::cmd_t               cmd_i,
  input  logic [31:0]                  func_i,
  input  logic [31:0]                  value_i,
  input  logic                         out_ready_i,
  output ccfb_pkg::sts_t               sts_o,
  output logic                         out_valid_o,
  output logic [ccfb_pkg::WORD_W-1:0]  out_word_o,
  output logic                         out_last_o
);

  logic [95:0]                  body_q;
  logic [15:0]                  crc_q;
  logic                         out_valid_q;
  logic [ccfb_pkg::WORD_W-1:0]  out_word_q, word_d;
  logic                         out_last_q;
  logic [7:0]                   body_b, crc_b, hdr_b, data_b, stuff_b, crc_in;

  assign body_b = body_q[95:88];
  assign crc_b  = crc_q[15:8];
  assign hdr_b  = ccfb_pkg::hdr_byte(cmd_i.hdr_idx);
  assign data_b = (cmd_i.src == ccfb_pkg::SRC_CRC) ? crc_b : body_b;
  assign crc_in = (cmd_i.src == ccfb_pkg::SRC_HDR) ? hdr_b : body_b;

  always_comb begin
    if (cmd_i.esc_hi) begin
      stuff_b = ccfb_pkg::FLAG_ESC;
    end else if (cmd_i.esc_lo) begin
      stuff_b = data_b - ccfb_pkg::ESC_OFFSET;
    end else begin
      stuff_b = data_b;
    end
  end

  always_comb begin
    case (cmd_i.src) inside
      ccfb_pkg::SRC_STOP:  word_d = ccfb_pkg::WORD_SPOOL_STOP;
      ccfb_pkg::SRC_SOF:   word_d = {4'h0, ccfb_pkg::FLAG_START};
      ccfb_pkg::SRC_HDR:   word_d = {4'h0, hdr_b};
      ccfb_pkg::SRC_BODY,
      ccfb_pkg::SRC_CRC:   word_d = {4'h0, stuff_b};
      ccfb_pkg::SRC_EOF:   word_d = {4'h0, ccfb_pkg::FLAG_END};
      ccfb_pkg::SRC_SPOOL: word_d = ccfb_pkg::WORD_SPOOL_START;
      default:             word_d = ccfb_pkg::WORD_SPOOL_START;
    endcase
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.body_flag = ccfb_pkg::is_flag(body_b);
  assign sts_o.crc_flag  = ccfb_pkg::is_flag(crc_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q <= word_d;
      out_last_q <= cmd_i.last;
    end
    if (cmd_i.load) begin
      body_q <= {func_i, {4{ccfb_pkg::STATUS_BYTE}}, value_i};
    end else if (cmd_i.shift && (cmd_i.src == ccfb_pkg::SRC_BODY)) begin
      body_q <= {body_q[87:0], 8'h00};
    end
    if (cmd_i.load) begin
      crc_q <= ccfb_pkg::CRC_INIT;
    end else if (cmd_i.crc_upd) begin
      crc_q <= ccfb_pkg::crc_byte(crc_q, crc_in);
    end else if (cmd_i.shift && (cmd_i.src == ccfb_pkg::SRC_CRC)) begin
      crc_q <= {crc_q[7:0], 8'h00};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("word loaded over a pending word");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_word_q == ccfb_pkg::WORD_SPOOL_START))
    else $error("last flag on a word other than spool start");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !cmd_i.emit)
    else $error("load and emit in one cycle");

endmodule
